// ===== src/rsbk_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsbk_pkg: shared types and constants of the record sorter
// Record layout, store sizing, state codes, register indexes and the
// ordering function used by every sort cell.
// ---------------------------------------------------------------------------
package rsbk_pkg;

    // store sizing
    localparam int MAX_RECORDS = 64;
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int IDX_W       = $clog2(MAX_RECORDS);

    // record fields
    localparam int TIME_W  = 16;
    localparam int PULSE_W = 8;
    localparam int DATA_W  = TIME_W + PULSE_W;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SELECT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = CFG_IDX_W'(1);

    typedef struct packed {
        logic [PULSE_W-1:0] pulse;
        logic [TIME_W-1:0]  time_ms;
    } t_record;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } t_state;

    // per-cell control from the sequencer
    typedef struct packed {
        logic load;
        logic shift;
        logic swap_right_en;
        logic swap_left_en;
        logic key_select;
        logic descending;
    } t_cell_ctrl;

    // true if record a must precede record b, false on equal keys
    function automatic logic goes_before(t_record a, t_record b, logic key_sel, logic desc);
        logic [TIME_W-1:0] ka;
        logic [TIME_W-1:0] kb;
        ka = key_sel ? TIME_W'(a.pulse) : a.time_ms;
        kb = key_sel ? TIME_W'(b.pulse) : b.time_ms;
        return desc ? (ka > kb) : (ka < kb);
    endfunction

endpackage

// ===== src/rsbk_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsbk_cell: one slot of the sorting chain
// Holds one record. Loads a new record, takes part in an odd-even
// compare-exchange with one neighbor, or shifts toward the output end.
// ---------------------------------------------------------------------------
module rsbk_cell (
    input  logic                i_clk,
    input  rsbk_pkg::t_cell_ctrl i_ctrl,
    input  rsbk_pkg::t_record   i_in_rec,
    input  rsbk_pkg::t_record   i_left_rec,
    input  rsbk_pkg::t_record   i_right_rec,
    output rsbk_pkg::t_record   o_rec
);
    import rsbk_pkg::*;

    t_record r_rec;
    t_record n_rec;
    logic    take_right;
    logic    take_left;

    // exchange decisions, each pair sees the same strict compare
    assign take_right = i_ctrl.swap_right_en &&
                        goes_before(i_right_rec, r_rec, i_ctrl.key_select, i_ctrl.descending);
    assign take_left  = i_ctrl.swap_left_en &&
                        goes_before(r_rec, i_left_rec, i_ctrl.key_select, i_ctrl.descending);

    // next record select
    always_comb begin
        n_rec = r_rec;
        if (i_ctrl.load) begin
            n_rec = i_in_rec;
        end else if (i_ctrl.shift) begin
            n_rec = i_right_rec;
        end else if (take_right) begin
            n_rec = i_right_rec;
        end else if (take_left) begin
            n_rec = i_left_rec;
        end
    end

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec = r_rec;

endmodule

// ===== src/record_sorter_by_key.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// record_sorter_by_key: stable sorter for batches of time/pulse records
// Records fill a row of cells in arrival order, one per cycle. The record
// marked last starts an odd-even transposition sort over the filled cells,
// after which the row shifts out one sorted record per cycle while the
// output is ready. The sort of a batch of n records runs n exchange phases.
// Throughput: one record per cycle while loading and, while the output is
// ready, while emitting; input is held off during the n sort phases and
// the n output transfers.
// Reset clears count, drop flag, registers and state; cells need no clear.
// ---------------------------------------------------------------------------
module record_sorter_by_key (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [23:0]                       i_s_axis_tdata,  // time_ms[15:0], pulse[23:16]
    input  logic                              i_s_axis_tlast,  // batch_end
    // output stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [23:0]                       o_m_axis_tdata,  // out_time_ms[15:0], out_pulse[23:16]
    output logic                              o_m_axis_tlast,  // run_last
    output logic                              o_m_axis_tuser,  // overflowed
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rsbk_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rsbk_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rsbk_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [IDX_W-1:0]  r_phase;
    logic [IDX_W-1:0]  n_phase;
    logic              r_drop;
    logic              n_drop;
    logic              r_key_select;
    logic              r_descending;
    logic [CNT_W-1:0]  count_m1;

    logic              in_xfer;
    logic              out_xfer;
    logic              sort_active;
    logic              shift_active;
    logic              sort_done;

    t_record           in_rec;
    t_record           cell_rec [MAX_RECORDS];
    t_cell_ctrl        cell_ctrl [MAX_RECORDS];

    // handshakes
    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer = o_m_axis_tvalid && i_m_axis_tready;
    assign o_cfg_ready = 1'b1;

    assign count_m1  = r_count - CNT_W'(1);
    assign sort_done = (r_phase == count_m1[IDX_W-1:0]);

    assign in_rec.time_ms = i_s_axis_tdata[TIME_W-1:0];
    assign in_rec.pulse   = i_s_axis_tdata[DATA_W-1:TIME_W];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_select <= 1'b0;
            r_descending <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KEY_SELECT: r_key_select <= i_cfg_data[0];
                CFG_DESCENDING: r_descending <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (in_xfer && i_s_axis_tlast) begin
                    n_state = (n_count == '0) ? ST_LOAD : ST_SORT;
                end
            end
            ST_SORT: begin
                if (sort_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_xfer && r_count == CNT_W'(1)) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        sort_active     = 1'b0;
        unique case (r_state)
            ST_LOAD: o_s_axis_tready = 1'b1;
            ST_SORT: sort_active     = 1'b1;
            ST_EMIT: o_m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    assign shift_active = out_xfer;

    // count, drop flag and phase counter
    always_comb begin
        n_count = r_count;
        n_drop  = r_drop;
        n_phase = r_phase;
        if (in_xfer) begin
            if (r_count < CNT_W'(MAX_RECORDS)) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_drop = 1'b1;
            end
            // empty batch end leaves nothing to emit
            if (i_s_axis_tlast && n_count == '0) begin
                n_drop = 1'b0;
            end
            n_phase = '0;
        end
        if (sort_active) begin
            n_phase = r_phase + IDX_W'(1);
        end
        if (out_xfer) begin
            n_count = count_m1;
            if (r_count == CNT_W'(1)) begin
                n_drop = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_phase <= n_phase;
        end
    end

    // row of cells
    for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
        t_record left_rec;
        t_record right_rec;

        if (i == 0) begin : g_head
            assign left_rec = cell_rec[i];
            assign cell_ctrl[i].swap_left_en = 1'b0;
        end else begin : g_mid_left
            assign left_rec = cell_rec[i-1];
            // paired with the left neighbor when that one starts the pair
            assign cell_ctrl[i].swap_left_en = sort_active &&
                (r_phase[0] == 1'((i + 1) % 2)) && (r_count > CNT_W'(i));
        end

        if (i == MAX_RECORDS - 1) begin : g_tail
            assign right_rec = cell_rec[i];
            assign cell_ctrl[i].swap_right_en = 1'b0;
        end else begin : g_mid_right
            assign right_rec = cell_rec[i+1];
            // this cell starts a pair on matching phase parity
            assign cell_ctrl[i].swap_right_en = sort_active &&
                (r_phase[0] == 1'(i % 2)) && (r_count > CNT_W'(i + 1));
        end

        assign cell_ctrl[i].load       = in_xfer && (r_count == CNT_W'(i));
        assign cell_ctrl[i].shift      = shift_active;
        assign cell_ctrl[i].key_select = r_key_select;
        assign cell_ctrl[i].descending = r_descending;

        rsbk_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (cell_ctrl[i]),
            .i_in_rec    (in_rec),
            .i_left_rec  (left_rec),
            .i_right_rec (right_rec),
            .o_rec       (cell_rec[i])
        );
    end

    // output from the head cell
    assign o_m_axis_tdata = {cell_rec[0].pulse, cell_rec[0].time_ms};
    assign o_m_axis_tlast = (r_count == CNT_W'(1));
    assign o_m_axis_tuser = r_drop;

    // assertions
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input and output sides active together");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RECORDS))
        else $error("record count beyond capacity");

    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid || sort_active) |-> (r_count != '0))
        else $error("sort or emission with empty store");

    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_m_axis_tlast) |=> (o_s_axis_tready && r_count == '0 && !r_drop))
        else $error("input not reopened clean after final result");

endmodule
